[hw/rtl/approach_distance_light_controller_macros.svh]
// Assertion macros for the approach distance light controller.
`ifndef APPROACH_DISTANCE_LIGHT_CONTROLLER_MACROS_SVH
`define APPROACH_DISTANCE_LIGHT_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under active-low reset.
`define ADLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adlc assertion failed");

// Next-cycle implication under active-low reset.
`define ADLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adlc assertion failed");

`else

`define ADLC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ADLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/adlc_pkg.sv]
// Types, codes and helpers for the approach distance light controller.
package adlc_pkg;

    localparam int DIST_W  = 16;
    localparam int TIME_W  = 32;
    localparam int MODE_W  = 3;
    localparam int DIR_W   = 2;
    localparam int LIGHT_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = DIST_W + TIME_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = MODE_W + DIR_W + LIGHT_W;
    localparam int OUT_USER_W = 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_INIT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_APPR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RETR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERR  = 3'd4;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_APPR = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RETR = 2'd2;

    localparam logic [LIGHT_W-1:0] LC_NONE   = 3'd0;
    localparam logic [LIGHT_W-1:0] LC_OFF    = 3'd1;
    localparam logic [LIGHT_W-1:0] LC_GREEN  = 3'd2;
    localparam logic [LIGHT_W-1:0] LC_YELLOW = 3'd3;
    localparam logic [LIGHT_W-1:0] LC_RED    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DIST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DIST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 3'd5;

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_APPR = 5'b00100,
        ST_RETR = 5'b01000,
        ST_ERR  = 5'b10000
    } state_t;

    function automatic logic [MODE_W-1:0] mode_code(input state_t st);
        logic [MODE_W-1:0] code;
        case (st)
            ST_INIT: code = MODE_INIT;
            ST_IDLE: code = MODE_IDLE;
            ST_APPR: code = MODE_APPR;
            ST_RETR: code = MODE_RETR;
            default: code = MODE_ERR;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/approach_distance_light_controller.sv]
// Top level of the approach distance light controller.
//
//  channel   direction  payload
//  s_axis    in         tdata: distance_mm, time_ms; tuser: out_of_range, lamp_test_ok
//  m_axis    out        tdata: mode, direction, light_cmd; tuser: lamp_test_run
//  cfg       in         cfg_index, cfg_data (always ready)
//
//  One request per cycle sustained while m_axis_tready is high; from s_axis to m_axis:
//  an input register, then one pass of compare and subtract logic into the
//  result register, which also updates state. The input side stalls only when
//  both registers hold requests and m_axis_tready is low. Reset puts the state
//  in initializing, the previous distance at its maximum and the reference time at zero.
`include "approach_distance_light_controller_macros.svh"

module approach_distance_light_controller
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] distance_mm, [47:16] time_ms
    input  logic [adlc_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // [0] out_of_range, [1] lamp_test_ok
    input  logic [adlc_pkg::IN_USER_W-1:0]         s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [2:0] mode, [4:3] direction, [7:5] light_cmd
    output logic [adlc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // [0] lamp_test_run
    output logic [adlc_pkg::OUT_USER_W-1:0]        m_axis_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [adlc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [adlc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [adlc_pkg::DIST_W-1:0] max_dist_reg;
    logic [adlc_pkg::DIST_W-1:0] far_dist_reg;
    logic [adlc_pkg::DIST_W-1:0] near_dist_reg;
    logic [adlc_pkg::DIST_W-1:0] move_dist_reg;
    logic [adlc_pkg::TIME_W-1:0] move_time_reg;
    logic [adlc_pkg::TIME_W-1:0] hold_time_reg;

    logic                        in_valid_reg;
    logic [adlc_pkg::DIST_W-1:0] in_dist_reg;
    logic                        in_oor_reg;
    logic [adlc_pkg::TIME_W-1:0] in_time_reg;
    logic                        in_lamp_ok_reg;

    adlc_pkg::state_t            state_reg;
    adlc_pkg::state_t            state_next;
    logic [adlc_pkg::DIST_W-1:0] last_dist_reg;
    logic [adlc_pkg::TIME_W-1:0] ref_time_reg;
    logic [adlc_pkg::TIME_W-1:0] ref_time_next;

    logic                         out_valid_reg;
    logic [adlc_pkg::MODE_W-1:0]  out_mode_reg;
    logic [adlc_pkg::DIR_W-1:0]   out_dir_reg;
    logic [adlc_pkg::LIGHT_W-1:0] out_light_reg;
    logic                         out_lamp_run_reg;

    logic                         advance;
    logic [adlc_pkg::DIST_W-1:0]  dist_eff;
    logic [adlc_pkg::TIME_W-1:0]  dt;
    logic                         positive;
    logic [adlc_pkg::DIST_W-1:0]  mag;
    logic [adlc_pkg::DIR_W-1:0]   dir;
    logic [adlc_pkg::LIGHT_W-1:0] light_pick;
    logic [adlc_pkg::LIGHT_W-1:0] light_next;
    logic                         lamp_run_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_light_reg, out_dir_reg, out_mode_reg};
    assign m_axis_tuser  = out_lamp_run_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg  <= '0;
            far_dist_reg  <= '0;
            near_dist_reg <= '0;
            move_dist_reg <= '0;
            move_time_reg <= '0;
            hold_time_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                adlc_pkg::CFG_MAX_DIST:  max_dist_reg  <= cfg_data[adlc_pkg::DIST_W-1:0];
                adlc_pkg::CFG_FAR_DIST:  far_dist_reg  <= cfg_data[adlc_pkg::DIST_W-1:0];
                adlc_pkg::CFG_NEAR_DIST: near_dist_reg <= cfg_data[adlc_pkg::DIST_W-1:0];
                adlc_pkg::CFG_MOVE_DIST: move_dist_reg <= cfg_data[adlc_pkg::DIST_W-1:0];
                adlc_pkg::CFG_MOVE_TIME: move_time_reg <= cfg_data[adlc_pkg::TIME_W-1:0];
                adlc_pkg::CFG_HOLD_TIME: hold_time_reg <= cfg_data[adlc_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_dist_reg    <= s_axis_tdata[adlc_pkg::DIST_W-1:0];
            in_time_reg    <= s_axis_tdata[adlc_pkg::IN_DATA_W-1:adlc_pkg::DIST_W];
            in_oor_reg     <= s_axis_tuser[0];
            in_lamp_ok_reg <= s_axis_tuser[1];
        end
    end

    always_comb
    begin
        dist_eff = in_oor_reg ? adlc_pkg::DIST_MAX : in_dist_reg;
        dt       = in_time_reg - ref_time_reg;
        positive = dist_eff > last_dist_reg;
        mag      = positive ? (dist_eff - last_dist_reg) : (last_dist_reg - dist_eff);

        dir = adlc_pkg::DIR_STOP;
        if ((dt > move_time_reg) && (mag > move_dist_reg))
        begin
            dir = positive ? adlc_pkg::DIR_RETR : adlc_pkg::DIR_APPR;
        end

        if (dist_eff > max_dist_reg)
            light_pick = adlc_pkg::LC_OFF;
        else if (dist_eff > far_dist_reg)
            light_pick = adlc_pkg::LC_GREEN;
        else if (dist_eff > near_dist_reg)
            light_pick = adlc_pkg::LC_YELLOW;
        else
            light_pick = adlc_pkg::LC_RED;

        state_next    = state_reg;
        ref_time_next = ref_time_reg;
        light_next    = adlc_pkg::LC_NONE;
        lamp_run_next = 1'b0;

        case (state_reg)
            adlc_pkg::ST_INIT:
            begin
                ref_time_next = in_time_reg;
                lamp_run_next = 1'b1;
                state_next    = in_lamp_ok_reg ? adlc_pkg::ST_IDLE : adlc_pkg::ST_ERR;
            end
            adlc_pkg::ST_IDLE:
            begin
                ref_time_next = in_time_reg;
                if (dir == adlc_pkg::DIR_STOP)
                    light_next = adlc_pkg::LC_OFF;
                else
                    state_next = (dir == adlc_pkg::DIR_RETR) ? adlc_pkg::ST_RETR
                                                              : adlc_pkg::ST_APPR;
            end
            adlc_pkg::ST_APPR, adlc_pkg::ST_RETR:
            begin
                light_next = light_pick;
                if (dir == adlc_pkg::DIR_STOP)
                begin
                    if (dt > hold_time_reg)
                    begin
                        light_next = adlc_pkg::LC_OFF;
                        state_next = adlc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ref_time_next = in_time_reg;
                    state_next    = (dir == adlc_pkg::DIR_RETR) ? adlc_pkg::ST_RETR
                                                                 : adlc_pkg::ST_APPR;
                end
            end
            adlc_pkg::ST_ERR:
            begin
                state_next = adlc_pkg::ST_ERR;
            end
            default:
            begin
                state_next = adlc_pkg::ST_ERR;
            end
        endcase
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adlc_pkg::ST_INIT;
            last_dist_reg <= adlc_pkg::DIST_MAX;
            ref_time_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                last_dist_reg <= dist_eff;
                ref_time_reg  <= ref_time_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mode_reg     <= adlc_pkg::mode_code(state_next);
            out_dir_reg      <= dir;
            out_light_reg    <= light_next;
            out_lamp_run_reg <= lamp_run_next;
        end
    end

    `ADLC_ASSERT_NEXT(a_err_sticky, clk, rst_n, state_reg == adlc_pkg::ST_ERR,
        state_reg == adlc_pkg::ST_ERR)
    `ADLC_ASSERT_SAME(a_lamp_run_mode, clk, rst_n, out_valid_reg && out_lamp_run_reg,
        out_mode_reg == adlc_pkg::MODE_IDLE || out_mode_reg == adlc_pkg::MODE_ERR)
    `ADLC_ASSERT_SAME(a_light_in_motion, clk, rst_n,
        out_valid_reg && (out_light_reg == adlc_pkg::LC_GREEN
            || out_light_reg == adlc_pkg::LC_YELLOW || out_light_reg == adlc_pkg::LC_RED),
        out_mode_reg == adlc_pkg::MODE_APPR || out_mode_reg == adlc_pkg::MODE_RETR)
    `ADLC_ASSERT_NEXT(a_no_result_from_empty, clk, rst_n, !in_valid_reg && !out_valid_reg,
        !out_valid_reg)
    `ADLC_ASSERT_SAME(a_dir_code, clk, rst_n, out_valid_reg,
        out_dir_reg == adlc_pkg::DIR_STOP || out_dir_reg == adlc_pkg::DIR_APPR
            || out_dir_reg == adlc_pkg::DIR_RETR)

endmodule
